[rtl/shortest_superstring_length_top_assert.svh]
// Assertion macros for the superstring length block.
`ifndef SHORTEST_SUPERSTRING_LENGTH_TOP_ASSERT_SVH
`define SHORTEST_SUPERSTRING_LENGTH_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ssl_pkg.sv]
// Shared constants for the superstring length block.
`default_nettype none
package ssl_pkg;
  localparam int CHAR_W      = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int RES_W       = 10;
  localparam int OUT_TDATA_W = 16;
endpackage
`default_nettype wire

[rtl/shortest_superstring_length_top.sv]
// Shortest common superstring length: load strings, build overlaps, search all orderings.
// Load: one character word per cycle; the set-end word starts the search.
// Overlap phase: per ordered pair, read both lengths, then try overlap lengths from longest
//   down to zero, comparing characters (two read ports, one compare per read).
// Order search: depth-first walk; n! leaves for n strings.
// Result is held in an output register; input stalls until the search ends and
//   the result register is free.
// Reset (rst_n, synchronous, active low) empties the set and clears the flags.
`default_nettype none
module shortest_superstring_length_top #(
  parameter int MAX_STRINGS = 8,
  parameter int MAX_CHARS   = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [ssl_pkg::IN_TDATA_W-1:0]   in_tdata,   // char_code
  input  wire                              in_tuser,   // last_in_string
  input  wire                              in_tlast,   // last_in_set
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [ssl_pkg::OUT_TDATA_W-1:0]  out_tdata,  // superstring_length, zero pad
  output logic                             out_tuser   // overflow
);
  localparam int IW  = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
  localparam int NW  = $clog2(MAX_STRINGS + 1);
  localparam int CW  = $clog2(MAX_CHARS + 1);
  localparam int AW  = (MAX_STRINGS * MAX_CHARS > 1) ? $clog2(MAX_STRINGS * MAX_CHARS) : 1;
  localparam int OW  = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS * MAX_STRINGS) : 1;
  localparam int SW  = $clog2(MAX_STRINGS * MAX_CHARS + 1);
  localparam int CD  = MAX_STRINGS * MAX_CHARS;
  localparam int OD  = MAX_STRINGS * MAX_STRINGS;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_LA   = 4'd1;
  localparam logic [3:0] S_LB   = 4'd2;
  localparam logic [3:0] S_K    = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_CMP  = 4'd5;
  localparam logic [3:0] S_TRY  = 4'd6;
  localparam logic [3:0] S_WAIT = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]    state_r;
  logic [NW-1:0] cnt_r, n_r;
  logic [CW-1:0] wp_r;
  logic          ovf_r;
  logic [CW-1:0] len_r [MAX_STRINGS];
  logic [IW-1:0] a_r, b_r;
  logic [CW-1:0] la_r, lb_r, k_r, t_r;
  logic [IW-1:0] lvl_r;
  logic [NW-1:0] cand_r [MAX_STRINGS];
  logic [IW-1:0] path_r [MAX_STRINGS];
  logic [SW-1:0] cost_r [MAX_STRINGS];
  logic [MAX_STRINGS-1:0] used_r;
  logic [CW-1:0] lenc_r;
  logic [SW-1:0] best_r;
  logic          out_valid_r;
  logic [ssl_pkg::RES_W-1:0] out_len_r;
  logic          out_ovf_r;

  // character store, one write and two read ports
  logic [ssl_pkg::CHAR_W-1:0] cmem [CD];
  logic [ssl_pkg::CHAR_W-1:0] ca_q, cb_q;
  logic [AW-1:0] cwa, cra, crb;
  logic          cwe;
  // overlap table
  logic [CW-1:0] omem [OD];
  logic [CW-1:0] ov_q;
  logic [OW-1:0] owa, ora;
  logic          owe;
  logic [CW-1:0] owd;

  logic          acc, end_str, stored, cnt_full;
  logic [NW-1:0] cnt_inc;
  logic [IW-1:0] len_idx;
  logic [CW-1:0] len_rd;
  logic [NW-1:0] cur_c;
  logic [IW-1:0] prev_p;
  logic [SW-1:0] new_cost;
  logic          pair_last_b, pair_last_a, pair_done;

  assign acc      = in_tvalid && in_tready;
  assign end_str  = in_tuser || in_tlast;
  assign cnt_full = (cnt_r >= NW'(MAX_STRINGS));
  assign stored   = !cnt_full && (wp_r < CW'(MAX_CHARS));
  assign cnt_inc  = cnt_full ? cnt_r : cnt_r + 1'b1;

  assign cur_c  = cand_r[lvl_r];
  assign prev_p = (lvl_r == '0) ? '0 : path_r[lvl_r - 1'b1];

  always_comb begin
    unique case (state_r)
      S_LA:    len_idx = a_r;
      S_LB:    len_idx = b_r;
      default: len_idx = cur_c[IW-1:0];
    endcase
  end
  assign len_rd = len_r[len_idx];

  assign new_cost = cost_r[lvl_r] + SW'(lenc_r) - ((lvl_r == '0) ? '0 : SW'(ov_q));
  assign pair_last_b = (NW'(b_r) + 1'b1 == n_r);
  assign pair_last_a = (NW'(a_r) + 1'b1 == n_r);

  assign cwe = acc && stored;
  assign cwa = AW'(cnt_r[IW-1:0]) * AW'(MAX_CHARS) + AW'(wp_r);
  assign cra = AW'(a_r) * AW'(MAX_CHARS) + AW'(la_r - k_r + t_r);
  assign crb = AW'(b_r) * AW'(MAX_CHARS) + AW'(t_r);
  assign owa = OW'(a_r) * OW'(MAX_STRINGS) + OW'(b_r);
  assign ora = OW'(prev_p) * OW'(MAX_STRINGS) + OW'(cur_c[IW-1:0]);
  assign owe = ((state_r == S_K) && (k_r == '0)) ||
               ((state_r == S_CMP) && (ca_q == cb_q) && (t_r + 1'b1 == k_r));
  assign owd = (state_r == S_K) ? '0 : k_r;
  // last overlap entry is being written this cycle
  assign pair_done = owe && pair_last_b && pair_last_a;

  always_ff @(posedge clk) begin
    if (cwe) cmem[cwa] <= in_tdata[ssl_pkg::CHAR_W-1:0];
    ca_q <= cmem[cra];
    cb_q <= cmem[crb];
  end

  always_ff @(posedge clk) begin
    if (owe) omem[owa] <= owd;
    ov_q <= omem[ora];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      wp_r        <= '0;
      ovf_r       <= 1'b0;
      n_r         <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_STRINGS; i++) len_r[i] <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (acc) begin
            if (stored) len_r[cnt_r[IW-1:0]] <= wp_r + 1'b1;
            else ovf_r <= 1'b1;
            if (end_str) begin
              cnt_r <= cnt_inc;
              wp_r  <= '0;
            end else if (stored) begin
              wp_r <= wp_r + 1'b1;
            end
            if (in_tlast) begin
              n_r <= end_str ? cnt_inc : cnt_r;
              a_r <= '0;
              b_r <= '0;
              if (cnt_inc == '0) begin
                best_r  <= '0;
                state_r <= S_FIN;
              end else begin
                state_r <= S_LA;
              end
            end
          end
        end
        S_LA: begin
          la_r    <= len_rd;
          state_r <= S_LB;
        end
        S_LB: begin
          lb_r    <= len_rd;
          k_r     <= la_r;
          state_r <= S_K;
        end
        S_K: begin
          t_r <= '0;
          if (k_r == '0 || k_r <= lb_r)
            state_r <= (k_r == '0) ? (pair_done ? S_TRY : S_LA) : S_RD;
          else k_r <= k_r - 1'b1;
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (ca_q != cb_q) begin
            k_r     <= k_r - 1'b1;
            state_r <= S_K;
          end else if (t_r + 1'b1 != k_r) begin
            t_r     <= t_r + 1'b1;
            state_r <= S_RD;
          end else begin
            state_r <= pair_done ? S_TRY : S_LA;
          end
        end
        S_TRY: begin
          if (cur_c >= n_r) begin
            if (lvl_r == '0) begin
              state_r <= S_FIN;
            end else begin
              used_r[path_r[lvl_r - 1'b1]] <= 1'b0;
              cand_r[lvl_r - 1'b1] <= NW'(path_r[lvl_r - 1'b1]) + 1'b1;
              lvl_r <= lvl_r - 1'b1;
            end
          end else if (used_r[cur_c[IW-1:0]]) begin
            cand_r[lvl_r] <= cur_c + 1'b1;
          end else begin
            lenc_r  <= len_rd;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (NW'(lvl_r) + 1'b1 == n_r) begin
            if (new_cost < best_r) best_r <= new_cost;
            cand_r[lvl_r] <= cur_c + 1'b1;
          end else begin
            path_r[lvl_r] <= cur_c[IW-1:0];
            used_r[cur_c[IW-1:0]] <= 1'b1;
            cost_r[lvl_r + 1'b1] <= new_cost;
            cand_r[lvl_r + 1'b1] <= '0;
            lvl_r <= lvl_r + 1'b1;
          end
          state_r <= S_TRY;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_len_r   <= ssl_pkg::RES_W'(best_r);
            out_ovf_r   <= ovf_r;
            cnt_r       <= '0;
            wp_r        <= '0;
            ovf_r       <= 1'b0;
            for (int i = 0; i < MAX_STRINGS; i++) len_r[i] <= '0;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
      // pair stepping after an overlap entry is written
      if (owe) begin
        if (pair_last_b) begin
          b_r <= '0;
          if (pair_last_a) begin
            lvl_r     <= '0;
            cand_r[0] <= '0;
            cost_r[0] <= '0;
            used_r    <= '0;
            best_r    <= '1;
          end else begin
            a_r <= a_r + 1'b1;
          end
        end else begin
          b_r <= b_r + 1'b1;
        end
      end
    end
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = ssl_pkg::OUT_TDATA_W'(out_len_r);
  assign out_tuser  = out_ovf_r;

`include "shortest_superstring_length_top_assert.svh"

  `SSL_ASSERT_IMP(a_lvl_in_range, state_r == S_TRY || state_r == S_WAIT, NW'(lvl_r) < n_r, "search level beyond string count")
  `SSL_ASSERT_NXT(a_set_end_starts, acc && in_tlast, state_r != S_LOAD, "set end did not start the search")
  `SSL_ASSERT_NXT(a_best_monotone, state_r == S_WAIT, best_r <= $past(best_r), "best length grew during search")
  `SSL_ASSERT_IMP(a_no_load_when_busy, state_r != S_LOAD, !in_tready, "input taken during search")

endmodule
`default_nettype wire
